>>> rtl/adarch_pkg.sv
// Package for the aperture deadband archiver: payload types, register indexes, widths.
package adarch_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int VALUE_W    = 32;
    localparam int PCT_W      = 16;
    localparam int GROUP_W    = 11;
    localparam int TICK_W     = 10;
    localparam int TS_W       = 64;

    // Fixed-point percent scale 25600 = 25 * 1024; the 1024 is folded into the threshold shift.
    localparam int PCT_SHIFT  = 10;
    localparam int DIFF_W     = VALUE_W + 1;
    localparam int PROD_W     = PCT_W + VALUE_W;
    localparam int CMP_W      = PROD_W - PCT_SHIFT;

    localparam logic [CFG_IDX_W-1:0] REG_IS_DISCRETE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ADAPTIVE_MODE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FINE_PCT      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COARSE_PCT    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_VALUE_SPAN    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OWN_GROUP     = 3'd5;

    typedef struct packed {
        logic                      sample_valid;
        logic signed [VALUE_W-1:0] sample_value;
        logic [TICK_W-1:0]         group_tick;
        logic [TS_W-1:0]           timestamp;
    } in_item_t;

    typedef struct packed {
        logic            archive;
        logic            validity_changed;
        logic            fine_crossed;
        logic            coarse_crossed;
        logic            auto_point;
        logic [TS_W-1:0] timestamp_out;
    } out_item_t;

endpackage

>>> rtl/aperture_deadband_archiver_core.sv
// Aperture deadband archiver: per-sample archiving decision with stored reference value.
//
// One transaction in, one transaction out. Each sample is registered at the input, judged
// combinationally (absolute change against a 16x32 aperture product, a validity check and a
// group match) and registered at the output. A sample is accepted every cycle unless the
// output stalls; the combinational decision loop that updates the stored value sets the rate,
// one sample per clock while not stalled. Configuration writes take effect on the next cycle.
module aperture_deadband_archiver_core
    import adarch_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  in_item_t              in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output out_item_t             out_data
);

    logic                      is_discrete_reg;
    logic                      adaptive_mode_reg;
    logic [PCT_W-1:0]          fine_pct_reg;
    logic [PCT_W-1:0]          coarse_pct_reg;
    logic [VALUE_W-1:0]        value_span_reg;
    logic [GROUP_W-1:0]        own_group_reg;

    logic                      initialized_reg;
    logic                      last_valid_reg;
    logic signed [VALUE_W-1:0] stored_reg;

    logic                      s1_valid_reg;
    in_item_t                  s1_data_reg;
    logic                      out_valid_reg;
    out_item_t                 out_data_reg;

    logic                      out_free;
    logic                      s1_advance;
    logic                      in_accept;

    logic signed [DIFF_W-1:0]  diff;
    logic [DIFF_W-1:0]         diff_mag;
    logic [VALUE_W-1:0]        old_mag;
    logic [VALUE_W-1:0]        base;
    logic [PROD_W-1:0]         fine_prod;
    logic [PROD_W-1:0]         coarse_prod;
    logic [CMP_W-1:0]          lhs;
    logic                      fine_hit;
    logic                      coarse_hit;

    logic                      vchg;
    logic                      fine;
    logic                      coarse;
    logic                      autop;
    logic                      reason;
    out_item_t                 result;

    assign out_free   = !out_valid_reg || !out_stall;
    assign s1_advance = s1_valid_reg && out_free;
    assign in_stall   = s1_valid_reg && !out_free;
    assign in_accept  = in_valid && !in_stall;

    assign out_valid  = out_valid_reg;
    assign out_data   = out_data_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            is_discrete_reg   <= 1'b0;
            adaptive_mode_reg <= 1'b0;
            fine_pct_reg      <= '0;
            coarse_pct_reg    <= '0;
            value_span_reg    <= '0;
            own_group_reg     <= '1;
        end
        else if (cfg_wr)
        begin
            case (cfg_addr)
                REG_IS_DISCRETE:   is_discrete_reg   <= cfg_wdata[0];
                REG_ADAPTIVE_MODE: adaptive_mode_reg <= cfg_wdata[0];
                REG_FINE_PCT:      fine_pct_reg      <= cfg_wdata[PCT_W-1:0];
                REG_COARSE_PCT:    coarse_pct_reg    <= cfg_wdata[PCT_W-1:0];
                REG_VALUE_SPAN:    value_span_reg    <= cfg_wdata[VALUE_W-1:0];
                REG_OWN_GROUP:     own_group_reg     <= cfg_wdata[GROUP_W-1:0];
                default:           ;
            endcase
        end
    end

    // aperture arithmetic
    always_comb
    begin
        diff     = DIFF_W'(s1_data_reg.sample_value) - DIFF_W'(stored_reg);
        diff_mag = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
        old_mag  = stored_reg[VALUE_W-1] ? VALUE_W'(-stored_reg) : VALUE_W'(stored_reg);
        base     = adaptive_mode_reg ? old_mag : value_span_reg;

        fine_prod   = PROD_W'(fine_pct_reg) * PROD_W'(base);
        coarse_prod = PROD_W'(coarse_pct_reg) * PROD_W'(base);

        // d * 25
        lhs = (CMP_W'(diff_mag) << 4) + (CMP_W'(diff_mag) << 3) + CMP_W'(diff_mag);

        fine_hit   = lhs > fine_prod[PROD_W-1:PCT_SHIFT];
        coarse_hit = lhs > coarse_prod[PROD_W-1:PCT_SHIFT];
    end

    // decision
    always_comb
    begin
        vchg   = !initialized_reg || (s1_data_reg.sample_valid != last_valid_reg);
        fine   = 1'b0;
        coarse = 1'b0;
        if (!vchg && s1_data_reg.sample_valid)
        begin
            if (is_discrete_reg)
            begin
                coarse = s1_data_reg.sample_value != stored_reg;
            end
            else
            begin
                fine   = fine_hit;
                coarse = coarse_hit;
            end
        end
        autop  = !own_group_reg[GROUP_W-1]
                 && (own_group_reg[TICK_W-1:0] == s1_data_reg.group_tick);
        reason = vchg || fine || coarse || autop;

        result.archive          = reason;
        result.validity_changed = vchg;
        result.fine_crossed     = fine;
        result.coarse_crossed   = coarse;
        result.auto_point       = autop;
        result.timestamp_out    = s1_data_reg.timestamp;
    end

    // signal state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            initialized_reg <= 1'b0;
            last_valid_reg  <= 1'b0;
            stored_reg      <= '0;
        end
        else if (s1_advance)
        begin
            initialized_reg <= 1'b1;
            last_valid_reg  <= s1_data_reg.sample_valid;
            if (reason)
            begin
                stored_reg <= s1_data_reg.sample_value;
            end
        end
    end

    // input and output registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_advance)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_data_reg <= in_data;
        end
        if (s1_advance)
        begin
            out_data_reg <= result;
        end
    end

endmodule

>>> bench/aperture_deadband_archiver_core_tb.sv
// Testbench for aperture_deadband_archiver_core: random/directed samples checked against a predictor.
`timescale 1ns / 100ps

module aperture_deadband_archiver_core_tb;
    import adarch_pkg::*;

    localparam longint unsigned PERCENT_SCALE = 100 * 256;
    localparam int              IDLE_PCT      = 30;
    localparam int              HOLD_CYCLES   = 400;
    localparam int              CYCLE_LIMIT   = 400000;
    localparam int              PHASE_ITEMS   = 240;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_wr    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    in_item_t              in_data   = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    out_item_t             out_data;

    // predictor copy of the registers and state
    logic                     cfg_discrete = 1'b0;
    logic                     cfg_adaptive = 1'b0;
    logic [PCT_W-1:0]         cfg_fine     = '0;
    logic [PCT_W-1:0]         cfg_coarse   = '0;
    logic [VALUE_W-1:0]       cfg_span     = '0;
    logic [GROUP_W-1:0]       cfg_group    = '1;
    logic                     seen_first   = 1'b0;
    logic                     prev_valid   = 1'b0;
    logic signed [VALUE_W-1:0] held_value  = '0;

    in_item_t  pending_samples[$];
    out_item_t expected_verdicts[$];

    logic signed [VALUE_W-1:0] gen_base = '0;
    logic  quiet_mode    = 1'b0;
    int    hold_requests = 0;
    int    holds_served  = 0;
    int    hold_left     = 0;
    int    fault_count   = 0;
    int    cycle_count   = 0;

    aperture_deadband_archiver_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr    (cfg_wr),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic out_item_t predict_verdict(in_item_t s);
        out_item_t       v;
        longint          cur;
        longint          old;
        longint unsigned change;
        longint unsigned basis;
        v = '0;
        v.timestamp_out = s.timestamp;
        if (!seen_first || s.sample_valid != prev_valid)
        begin
            seen_first = 1'b1;
            prev_valid = s.sample_valid;
            v.validity_changed = 1'b1;
        end
        else if (s.sample_valid)
        begin
            if (cfg_discrete)
                v.coarse_crossed = (s.sample_value != held_value);
            else
            begin
                cur = $signed(s.sample_value);
                old = $signed(held_value);
                change = (cur >= old) ? longint'(cur - old) : longint'(old - cur);
                change = change * PERCENT_SCALE;
                if (cfg_adaptive)
                    basis = (old < 0) ? -old : old;
                else
                    basis = cfg_span;
                v.fine_crossed   = change > cfg_fine * basis;
                v.coarse_crossed = change > cfg_coarse * basis;
            end
        end
        v.auto_point = !cfg_group[GROUP_W-1] && (cfg_group[TICK_W-1:0] == s.group_tick);
        v.archive = v.validity_changed | v.fine_crossed | v.coarse_crossed | v.auto_point;
        if (v.archive)
            held_value = s.sample_value;
        return v;
    endfunction

    function automatic in_item_t make_sample(logic vld, logic [VALUE_W-1:0] val,
                                             logic [TICK_W-1:0] tick, logic [TS_W-1:0] ts);
        in_item_t s;
        s.sample_valid = vld;
        s.sample_value = val;
        s.group_tick   = tick;
        s.timestamp    = ts;
        return s;
    endfunction

    // values wander around a base so aperture tests land on both sides
    function automatic in_item_t random_sample();
        in_item_t                  s;
        int unsigned               pick;
        logic signed [VALUE_W-1:0] delta;
        pick = $urandom_range(99);
        s.sample_valid = ($urandom_range(99) < 90);
        if (pick < 8)
            s.sample_value = $urandom;
        else if (pick < 20)
        begin
            case ($urandom_range(4))
                0: s.sample_value = 32'h8000_0000;
                1: s.sample_value = 32'h7FFF_FFFF;
                2: s.sample_value = '0;
                3: s.sample_value = -gen_base;
                default: s.sample_value = gen_base;
            endcase
        end
        else
        begin
            delta = $signed($urandom >> $urandom_range(31));
            if ($urandom_range(1))
                delta = -delta;
            s.sample_value = gen_base + delta;
        end
        if ($urandom_range(2) == 0)
            gen_base = s.sample_value;
        s.group_tick = ($urandom_range(99) < 20) ? cfg_group[TICK_W-1:0]
                                                 : TICK_W'($urandom_range(1023));
        s.timestamp  = {$urandom, $urandom};
        return s;
    endfunction

    task automatic report_fault(string what, out_item_t want, out_item_t got);
        if (fault_count < 10)
            $display({"%0t mismatch (%s): expected arch=%b vchg=%b fine=%b coarse=%b",
                      " auto=%b ts=%h, got arch=%b vchg=%b fine=%b coarse=%b auto=%b ts=%h"},
                     $realtime, what, want.archive, want.validity_changed, want.fine_crossed,
                     want.coarse_crossed, want.auto_point, want.timestamp_out, got.archive,
                     got.validity_changed, got.fine_crossed, got.coarse_crossed,
                     got.auto_point, got.timestamp_out);
        fault_count++;
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
                expected_verdicts.push_back(predict_verdict(in_data));
            if (in_valid && in_stall)
                in_valid <= 1'b1;
            else if (pending_samples.size() != 0
                     && (quiet_mode || $urandom_range(99) >= IDLE_PCT))
            begin
                in_data  <= pending_samples.pop_front();
                in_valid <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // monitor and receiver stall
    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        if (!rst_n)
        begin
            out_stall    <= 1'b0;
            hold_left    <= 0;
            holds_served <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_verdicts.size() == 0)
                    report_fault("unexpected transaction", '0, out_data);
                else
                begin
                    want = expected_verdicts.pop_front();
                    if (out_data !== want)
                        report_fault("field", want, out_data);
                end
            end
            if (hold_left != 0)
            begin
                out_stall <= 1'b1;
                hold_left <= hold_left - 1;
            end
            else if (holds_served != hold_requests)
            begin
                out_stall    <= 1'b1;
                hold_left    <= HOLD_CYCLES;
                holds_served <= holds_served + 1;
            end
            else
                out_stall <= quiet_mode ? 1'b0 : ($urandom_range(99) < IDLE_PCT);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("aperture_deadband_archiver_core_tb: errors");
            $finish;
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_wr    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= data;
        @(posedge clk);
    endtask

    task automatic apply_settings(bit disc, bit adapt, logic [PCT_W-1:0] fine,
                                  logic [PCT_W-1:0] coarse, logic [VALUE_W-1:0] span,
                                  logic [GROUP_W-1:0] group);
        cfg_discrete = disc;
        cfg_adaptive = adapt;
        cfg_fine     = fine;
        cfg_coarse   = coarse;
        cfg_span     = span;
        cfg_group    = group;
        write_reg(REG_IS_DISCRETE, CFG_DATA_W'(disc));
        write_reg(REG_ADAPTIVE_MODE, CFG_DATA_W'(adapt));
        write_reg(REG_FINE_PCT, CFG_DATA_W'(fine));
        write_reg(REG_COARSE_PCT, CFG_DATA_W'(coarse));
        write_reg(REG_VALUE_SPAN, span);
        write_reg(REG_OWN_GROUP, CFG_DATA_W'(group));
        cfg_wr <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_drained();
        while (pending_samples.size() != 0 || in_valid || expected_verdicts.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic run_random_phase(int n);
        repeat (n) pending_samples.push_back(random_sample());
        wait_drained();
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: span mode with zero span and apertures, no group
        pending_samples.push_back(make_sample(1'b1, 32'h0, 10'd0, 64'h0));
        pending_samples.push_back(make_sample(1'b1, 32'h0, 10'd0, 64'h1));
        pending_samples.push_back(make_sample(1'b1, 32'h1, 10'd1, 64'h2));
        pending_samples.push_back(make_sample(1'b1, 32'h7FFF_FFFF, 10'd1023, '1));
        pending_samples.push_back(make_sample(1'b1, 32'h8000_0000, 10'd1023, 64'h4));
        pending_samples.push_back(make_sample(1'b0, 32'h8000_0000, 10'd2, 64'h5));
        pending_samples.push_back(make_sample(1'b0, 32'h1234_5678, 10'd3, 64'h6));
        pending_samples.push_back(make_sample(1'b1, 32'h1234_5678, 10'd4, 64'h7));
        wait_drained();

        // adaptive: stored zero, exact aperture boundary, one past it
        apply_settings(1'b0, 1'b1, 16'd256, 16'd2560, 32'd0, 11'd5);
        pending_samples.push_back(make_sample(1'b1, 32'h0, 10'd5, 64'h10));
        pending_samples.push_back(make_sample(1'b1, 32'h0, 10'd6, 64'h11));
        pending_samples.push_back(make_sample(1'b1, 32'h1, 10'd6, 64'h12));
        pending_samples.push_back(make_sample(1'b1, 32'd6553600, 10'd6, 64'h13));
        pending_samples.push_back(make_sample(1'b1, 32'd6553600 + 32'd65536, 10'd6, 64'h14));
        pending_samples.push_back(make_sample(1'b1, 32'd6553600 + 32'd65537, 10'd6, 64'h15));
        pending_samples.push_back(make_sample(1'b1, -32'sd6553600, 10'd6, 64'h16));
        wait_drained();

        // discrete changes, invalid repeats, top group
        apply_settings(1'b1, 1'b0, 16'd0, 16'd0, 32'd0, 11'd1023);
        pending_samples.push_back(make_sample(1'b1, -32'sd6553600, 10'd7, 64'h20));
        pending_samples.push_back(make_sample(1'b1, -32'sd6553599, 10'd7, 64'h21));
        pending_samples.push_back(make_sample(1'b0, 32'h0, 10'd7, 64'h22));
        pending_samples.push_back(make_sample(1'b0, 32'h5, 10'd1023, 64'h23));
        wait_drained();

        // most negative group must not match tick zero
        apply_settings(1'b0, 1'b0, 16'd0, 16'd0, 32'd0, 11'h400);
        pending_samples.push_back(make_sample(1'b0, 32'h5, 10'd0, 64'h30));
        wait_drained();

        apply_settings(1'b0, 1'b0, 16'd256, 16'd2560, 32'd6553600, 11'd3);
        run_random_phase(PHASE_ITEMS);
        apply_settings(1'b0, 1'b1, 16'd512, 16'd5120, 32'd0, 11'd1023);
        run_random_phase(PHASE_ITEMS);
        apply_settings(1'b1, 1'b0, 16'd0, 16'd0, 32'd0, 11'h7FF);
        run_random_phase(PHASE_ITEMS);

        // receiver holds off while the sender keeps offering
        apply_settings(1'b0, 1'b0, 16'd0, 16'hFFFF, 32'hFFFF_FFFF, 11'd0);
        quiet_mode <= 1'b1;
        repeat (PHASE_ITEMS) pending_samples.push_back(random_sample());
        hold_requests <= hold_requests + 1;
        wait_drained();
        quiet_mode <= 1'b0;

        apply_settings(1'b0, 1'b1, 16'hFFFF, 16'd0, 32'd0, 11'h400);
        run_random_phase(PHASE_ITEMS);
        apply_settings(1'b0, 1'b0, 16'd0, 16'd0, 32'd0, 11'd512);
        run_random_phase(PHASE_ITEMS);
        repeat (2)
        begin
            apply_settings(1'($urandom_range(1)), 1'($urandom_range(1)),
                           PCT_W'($urandom >> $urandom_range(16, 31)),
                           PCT_W'($urandom >> $urandom_range(16, 31)),
                           $urandom >> $urandom_range(31),
                           GROUP_W'($urandom_range(2047)));
            run_random_phase(PHASE_ITEMS);
        end

        repeat (8) @(posedge clk);
        if (fault_count == 0)
            $display("aperture_deadband_archiver_core_tb: clean");
        else
            $display("aperture_deadband_archiver_core_tb: errors");
        $finish;
    end

endmodule

>>> aperture_deadband_archiver_core.f
rtl/adarch_pkg.sv
rtl/aperture_deadband_archiver_core.sv
bench/aperture_deadband_archiver_core_tb.sv
